[hw/rtl/bbc_pkg.sv]
package bbc_pkg;

  localparam int NumBuffersDef    = 64;
  localparam int RefCountWidthDef = 8;
  localparam int FifoDepth        = 2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FILL     = 3'd1;
  localparam logic [2:0] ST_NOBUF    = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_BADREL   = 3'd4;
  localparam logic [2:0] ST_SAT      = 3'd5;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] block_number;
    logic [5:0]  buffer_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0] granted_index;
    logic [2:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ACQUIRE,
    OP_RELEASE,
    OP_BAD_INDEX
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] block_number;
    logic [5:0]  buffer_index;
  } op_t;

  typedef struct packed {
    logic push;
    logic full;
  } fifo_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } fifo_rd_t;

  function automatic logic [5:0] to_gidx(input logic [7:0] v);
    return v[5:0];
  endfunction

endpackage

[hw/rtl/bbc_front.sv]
module bbc_front import bbc_pkg::*; #(
  parameter int NUM_BUFFERS = NumBuffersDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output fifo_wr_t wr_ctl,
  input  logic     fifo_full,
  output op_t      op_out
);

  logic     f_valid_r;
  op_t      f_op_r;
  op_t      op_nxt;
  logic     push;
  logic [8:0] idx_wide;

  assign idx_wide = 9'(in_data.buffer_index);
  assign push     = f_valid_r && !fifo_full;
  assign in_stall = f_valid_r && fifo_full;

  always_comb begin
    op_nxt.block_number = in_data.block_number;
    op_nxt.buffer_index = in_data.buffer_index;
    if (in_data.command == CMD_ACQUIRE) begin
      op_nxt.kind = OP_ACQUIRE;
    end else if (idx_wide >= 9'(NUM_BUFFERS)) begin
      op_nxt.kind = OP_BAD_INDEX;
    end else begin
      op_nxt.kind = OP_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      f_op_r <= op_nxt;
    end
  end

  assign wr_ctl.push = push;
  assign wr_ctl.full = fifo_full;
  assign op_out      = f_op_r;

endmodule

[hw/rtl/bbc_fifo.sv]
module bbc_fifo import bbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fifo_wr_t wr_ctl,
  input  op_t      wr_op,
  output logic     full,
  input  logic     pop,
  output fifo_rd_t rd_ctl,
  output op_t      rd_op
);

  op_t        mem_r [FifoDepth];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       empty;

  assign full  = cnt_r == 2'(FifoDepth);
  assign empty = cnt_r == 2'd0;
  assign rd_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_ctl.push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({wr_ctl.push, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (wr_ctl.push) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

  assign rd_ctl.pop   = pop && !empty;
  assign rd_ctl.empty = empty;

endmodule

[hw/rtl/bbc_back.sv]
module bbc_back import bbc_pkg::*; #(
  parameter int NUM_BUFFERS     = NumBuffersDef,
  parameter int REF_COUNT_WIDTH = RefCountWidthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fifo_rd_t  rd_ctl,
  input  op_t       rd_op,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IdxW = $clog2(NUM_BUFFERS);
  localparam int CW   = REF_COUNT_WIDTH;
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BUFFERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LOOK,
    S_SCAN,
    S_ALLOC
  } state_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [31:0]            tag_r   [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] valid_r;
  logic [CW-1:0]          cnt_r   [NUM_BUFFERS];
  logic [IdxW-1:0]        rank_r  [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] hit_vec_r;
  logic [NUM_BUFFERS-1:0] free_vec_r;
  logic [IdxW-1:0]        scan_r;
  logic [IdxW-1:0]        best_r;
  logic [IdxW-1:0]        best_rank_r;
  logic                   found_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_item_t              out_data_r;

  logic                   out_free;
  logic [8:0]             rel_wide;
  logic [IdxW-1:0]        rel_idx;
  logic [IdxW-1:0]        hit_idx;
  logic                   hit_any;

  assign out_free = !out_valid_r || !out_stall;
  assign rel_wide = 9'(op_r.buffer_index);
  assign rel_idx  = rel_wide[IdxW-1:0];
  assign hit_any  = |hit_vec_r;
  assign pop      = (state_r == S_IDLE) && !rd_ctl.empty;

  always_comb begin
    hit_idx = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_EVAL: begin
        if (op_r.kind != OP_ACQUIRE && out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_LOOK: begin
        if (hit_any && out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      found_r     <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        cnt_r[i]  <= '0;
        rank_r[i] <= IdxW'(i);
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (rd_ctl.pop) begin
            op_r    <= rd_op;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (op_r.kind)
            OP_ACQUIRE: begin
              for (int i = 0; i < NUM_BUFFERS; i++) begin
                hit_vec_r[i]  <= valid_r[i] && (tag_r[i] == op_r.block_number);
                free_vec_r[i] <= cnt_r[i] == '0;
              end
              state_r <= S_LOOK;
            end
            OP_RELEASE: begin
              if (out_free) begin
                out_data_r.granted_index <= op_r.buffer_index;
                if (cnt_r[rel_idx] == '0) begin
                  out_data_r.status <= ST_BADREL;
                end else begin
                  out_data_r.status <= ST_RELEASED;
                  cnt_r[rel_idx]    <= cnt_r[rel_idx] - CW'(1);
                  if (cnt_r[rel_idx] == CW'(1)) begin
                    for (int i = 0; i < NUM_BUFFERS; i++) begin
                      if (rank_r[i] < rank_r[rel_idx]) begin
                        rank_r[i] <= rank_r[i] + IdxW'(1);
                      end
                    end
                    rank_r[rel_idx] <= '0;
                  end
                end
                state_r <= S_IDLE;
              end
            end
            default: begin
              if (out_free) begin
                out_data_r.granted_index <= op_r.buffer_index;
                out_data_r.status        <= ST_BADREL;
                state_r                  <= S_IDLE;
              end
            end
          endcase
        end
        S_LOOK: begin
          if (hit_any) begin
            if (out_free) begin
              out_data_r.granted_index <= to_gidx(8'(hit_idx));
              if (cnt_r[hit_idx] == CntMax) begin
                out_data_r.status <= ST_SAT;
              end else begin
                out_data_r.status <= ST_HIT;
                cnt_r[hit_idx]    <= cnt_r[hit_idx] + CW'(1);
              end
              state_r <= S_IDLE;
            end
          end else begin
            scan_r  <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (free_vec_r[scan_r] && (!found_r || rank_r[scan_r] > best_rank_r)) begin
            found_r     <= 1'b1;
            best_r      <= scan_r;
            best_rank_r <= rank_r[scan_r];
          end
          if (scan_r == LastIdx) begin
            state_r <= S_ALLOC;
          end else begin
            scan_r <= scan_r + IdxW'(1);
          end
        end
        S_ALLOC: begin
          if (out_free) begin
            if (found_r) begin
              tag_r[best_r]            <= op_r.block_number;
              valid_r[best_r]          <= 1'b1;
              cnt_r[best_r]            <= CW'(1);
              out_data_r.granted_index <= to_gidx(8'(best_r));
              out_data_r.status        <= ST_FILL;
            end else begin
              out_data_r.granted_index <= '0;
              out_data_r.status        <= ST_NOBUF;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/block_buffer_cache_lru_top.sv]
// buffer cache manager for a pool of NUM_BUFFERS block buffers: acquire looks up a
// block by tag and counts a reference, or takes the least recently released free
// entry; release drops a reference. items are handled one at a time by the back
// end: a release or a bad release is answered from the evaluate state and a hit
// from the lookup state, while a miss first scans all entries and then allocates.
// output stalls hold each result back. a front register and a 2-entry queue
// take new beats while one is worked on.
module block_buffer_cache_lru_top import bbc_pkg::*; #(
  parameter int NUM_BUFFERS     = NumBuffersDef,
  parameter int REF_COUNT_WIDTH = RefCountWidthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  fifo_wr_t wr_ctl;
  fifo_rd_t rd_ctl;
  op_t      f_op;
  op_t      q_op;
  logic     fifo_full;
  logic     pop;

  bbc_front #(.NUM_BUFFERS(NUM_BUFFERS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .wr_ctl, .fifo_full, .op_out(f_op)
  );

  bbc_fifo u_fifo (
    .clk, .rst_n, .wr_ctl, .wr_op(f_op), .full(fifo_full),
    .pop, .rd_ctl, .rd_op(q_op)
  );

  bbc_back #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .REF_COUNT_WIDTH(REF_COUNT_WIDTH)
  ) u_back (
    .clk, .rst_n, .rd_ctl, .rd_op(q_op), .pop,
    .out_valid, .out_stall, .out_data
  );

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_SAT))
    else $error("illegal status");

  a_nobuf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NOBUF |-> out_data.granted_index == 6'd0)
    else $error("no-buffer result with nonzero index");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

[tb/bbc_checker.sv]
module bbc_checker import bbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = NumBuffersDef;
  localparam int CountMax = (1 << RefCountWidthDef) - 1;

  logic [31:0] tag_q [NB];
  logic        used_q [NB];
  int          refs_q [NB];
  int          rank_q [NB];
  out_item_t   grants_q [$];

  function automatic out_item_t cache_step(in_item_t it);
    out_item_t r;
    int        best;
    int        old;
    best = -1;
    if (it.command == CMD_ACQUIRE) begin
      for (int i = 0; i < NB; i++) begin
        if (used_q[i] && tag_q[i] == it.block_number) begin
          r.granted_index = i[5:0];
          if (refs_q[i] >= CountMax) begin
            r.status = ST_SAT;
          end else begin
            refs_q[i]++;
            r.status = ST_HIT;
          end
          return r;
        end
      end
      for (int i = 0; i < NB; i++) begin
        if (refs_q[i] == 0 && (best < 0 || rank_q[i] > rank_q[best])) best = i;
      end
      if (best < 0) begin
        r.granted_index = '0;
        r.status = ST_NOBUF;
        return r;
      end
      tag_q[best] = it.block_number;
      used_q[best] = 1'b1;
      refs_q[best] = 1;
      r.granted_index = best[5:0];
      r.status = ST_FILL;
      return r;
    end
    r.granted_index = it.buffer_index;
    if (int'(it.buffer_index) >= NB || refs_q[it.buffer_index] == 0) begin
      r.status = ST_BADREL;
      return r;
    end
    refs_q[it.buffer_index]--;
    if (refs_q[it.buffer_index] == 0) begin
      old = rank_q[it.buffer_index];
      for (int i = 0; i < NB; i++) if (rank_q[i] < old) rank_q[i]++;
      rank_q[it.buffer_index] = 0;
    end
    r.status = ST_RELEASED;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    for (int i = 0; i < NB; i++) begin
      tag_q[i] = '1;
      used_q[i] = 1'b0;
      refs_q[i] = 0;
      rank_q[i] = i;
    end
  end

  assign pending = grants_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) grants_q.push_back(cache_step(in_data));
      if (out_valid && !out_stall) begin
        if (grants_q.size() == 0) begin
          $display("%0t: unexpected beat, actual idx %0d status %0d", $time,
                   out_data.granted_index, out_data.status);
          fail_count++;
        end else begin
          want = grants_q.pop_front();
          if (want.granted_index !== out_data.granted_index) begin
            $display("%0t: granted_index expected %0d actual %0d", $time,
                     want.granted_index, out_data.granted_index);
            fail_count++;
          end
          if (want.status !== out_data.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[tb/block_buffer_cache_lru_top_tb.sv]
module block_buffer_cache_lru_top_tb import bbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  logic      no_idle = 1'b0;
  int        quiet_cycles = 0;
  logic [31:0] block_pool [48];

  always #2 clk = ~clk;

  block_buffer_cache_lru_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  bbc_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 38);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic cmd, input logic [31:0] blk, input logic [5:0] idx);
    in_item_t it;
    it.command = cmd;
    it.block_number = blk;
    it.buffer_index = idx;
    if (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic acquire(input logic [31:0] blk);
    send(CMD_ACQUIRE, blk, 6'($urandom));
  endtask

  task automatic release_buf(input logic [5:0] idx);
    send(CMD_RELEASE, $urandom, idx);
  endtask

  initial begin
    int acq_pct;
    for (int i = 0; i < 48; i++) block_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    acquire(32'hFFFF_FFFF);
    acquire(32'hFFFF_FFFF);
    release_buf(6'd63);
    release_buf(6'd63);
    release_buf(6'd63);
    release_buf(6'd0);
    acquire(32'h0000_0000);
    acquire(32'hFFFF_FFFE);
    acquire(32'h0000_0000);
    release_buf(6'd62);
    release_buf(6'd62);
    acquire(32'hAAAA_5555);
    acquire(32'h5555_AAAA);

    // saturate one entry's count
    for (int i = 0; i < 257; i++) acquire(32'h1234_5678);
    // exhaust the pool
    for (int i = 0; i < 70; i++) acquire($urandom);
    for (int s = 0; s < 3; s++) for (int i = 0; i < 64; i++) release_buf(i[5:0]);

    for (int p = 0; p < 8; p++) begin
      acq_pct = (p % 2 == 0) ? 70 : 40;
      no_idle <= (p == 3);
      for (int i = 0; i < 127; i++) begin
        if ($urandom_range(99) < acq_pct) begin
          if ($urandom_range(9) == 0) acquire($urandom);
          else acquire(block_pool[$urandom_range(47)]);
        end else begin
          release_buf(6'($urandom));
        end
      end
    end
    no_idle <= 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
